[rtl/cv2d_pkg.sv]
package cv2d_pkg;

	// default sizing of the block
	localparam int DEF_MAX_WIDTH       = 1024;
	localparam int DEF_MAX_KERNEL      = 7;
	localparam int DEF_COEFF_FRAC_BITS = 14;
	localparam int DEF_CHANNELS        = 3;

	// fixed field widths
	localparam int PIX_W   = 8;
	localparam int COEF_W  = 16;
	localparam int ROW_W   = 16;
	localparam int OCOL_W  = 10;
	localparam int WREG_W  = 11;
	localparam int PROD_W  = COEF_W + PIX_W + 1;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	// input commands
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_PIXEL = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	// register indexes
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CHAN   = 3'd2;
	localparam logic [2:0] REG_RADX   = 3'd3;
	localparam logic [2:0] REG_RADY   = 3'd4;

	// register reset values
	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [15:0] RST_HEIGHT = 16'd480;
	localparam logic [1:0]  RST_CHAN   = 2'd3;
	localparam logic [1:0]  RST_RAD    = 2'd1;

	// control from the tap sequencer to each lane
	typedef struct packed {
		logic clear;
		logic tap_s1;
	} lane_ctrl_t;

endpackage

[rtl/cv2d_in_if.sv]
interface cv2d_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [5:0]         coeff_index;
	logic signed [15:0] coeff_value;
	logic [7:0]         pixel_ch0;
	logic [7:0]         pixel_ch1;
	logic [7:0]         pixel_ch2;

	modport source (output valid, command, coeff_index, coeff_value,
		pixel_ch0, pixel_ch1, pixel_ch2, input ready);
	modport sink (input valid, command, coeff_index, coeff_value,
		pixel_ch0, pixel_ch1, pixel_ch2, output ready);
endinterface

[rtl/cv2d_out_if.sv]
interface cv2d_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_ch0;
	logic [7:0]  out_ch1;
	logic [7:0]  out_ch2;
	logic [15:0] out_row;
	logic [9:0]  out_col;
	logic        last_of_frame;

	modport source (output valid, out_ch0, out_ch1, out_ch2, out_row, out_col,
		last_of_frame, input ready);
	modport sink (input valid, out_ch0, out_ch1, out_ch2, out_row, out_col,
		last_of_frame, output ready);
endinterface

[rtl/cv2d_lane.sv]
module cv2d_lane #(
	parameter int ACC_W = 31
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cv2d_pkg::lane_ctrl_t                  ctrl,
	input  logic signed [cv2d_pkg::COEF_W-1:0]    coeff,
	input  logic [cv2d_pkg::PIX_W-1:0]            pixel,
	output logic signed [ACC_W-1:0]               acc
);
	import cv2d_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     val_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// tap valid follows the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s2 <= 1'b0;
		end else begin
			val_s2 <= ctrl.tap_s1;
		end
	end

	// coefficient times sample
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(coeff * $signed({1'b0, pixel}));
	end

	// window accumulator
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (val_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc = acc_q;
endmodule

[rtl/cv2d_merge.sv]
module cv2d_merge #(
	parameter int ACC_W           = 31,
	parameter int COEFF_FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic signed [ACC_W-1:0]           sum [3],
	input  logic [1:0]                        nch,
	input  logic [cv2d_pkg::ROW_W-1:0]        row,
	input  logic [cv2d_pkg::OCOL_W-1:0]       col,
	input  logic                              last,
	cv2d_out_if.source                        results
);
	import cv2d_pkg::*;

	logic [PIX_W-1:0] pix [3];
	logic             valid_q;
	logic [PIX_W-1:0] ch_q [3];
	logic [ROW_W-1:0] row_q;
	logic [OCOL_W-1:0] col_q;
	logic             last_q;

	// drop the fraction toward zero and clamp to a byte
	function automatic logic [PIX_W-1:0] sat(input logic signed [ACC_W-1:0] s);
		logic [ACC_W-1:0] q;
		q = ACC_W'($unsigned(s) >> COEFF_FRAC_BITS);
		if (s <= 0) begin
			return '0;
		end else if (q > ACC_W'(255)) begin
			return 8'd255;
		end else begin
			return q[PIX_W-1:0];
		end
	endfunction

	// merge the lanes, inactive channels read zero
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pix[c] = (c < int'(nch)) ? sat(sum[c]) : '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_q   <= pix;
			row_q  <= row;
			col_q  <= col;
			last_q <= last;
		end
	end

	assign results.valid         = valid_q;
	assign results.out_ch0       = ch_q[0];
	assign results.out_ch1       = ch_q[1];
	assign results.out_ch2       = ch_q[2];
	assign results.out_row       = row_q;
	assign results.out_col       = col_q;
	assign results.last_of_frame = last_q;
endmodule

[rtl/convolution_2d_replicate_border.sv]
// channel   | dir | beat
// ----------+-----+------------------------------------------------------
// items     | in  | command, coeff_index, coeff_value, pixel_ch0..2
// results   | out | out_ch0..2, out_row, out_col, last_of_frame
// apb       | in  | register write or read, image size, channels, radii
//
// a coefficient load is taken in the idle state; a pixel or flush passes the
// check state, and one that releases an output goes on through the mac, drain
// and emit states: the window is read one tap per cycle through the single
// line store read port while all channel lanes multiply and add in parallel.
// reset clears the positions and sets the config registers to their reset
// values; the kernel and line store hold whatever was written. a full output
// register stalls the block only when a new output is ready to be loaded.
module convolution_2d_replicate_border #(
	parameter int MAX_WIDTH       = cv2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL      = cv2d_pkg::DEF_MAX_KERNEL,
	parameter int COEFF_FRAC_BITS = cv2d_pkg::DEF_COEFF_FRAC_BITS,
	parameter int CHANNELS        = cv2d_pkg::DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cv2d_in_if.sink                       items,
	cv2d_out_if.source                    results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cv2d_pkg::APB_AW-1:0]   paddr,
	input  logic [cv2d_pkg::APB_DW-1:0]   pwdata,
	output logic [cv2d_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import cv2d_pkg::*;

	localparam int COEFF_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int CA_W        = (COEFF_DEPTH > 1) ? $clog2(COEFF_DEPTH) : 1;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int SLOT_W      = $clog2(MAX_KERNEL + 1);
	localparam int LA_W        = SLOT_W + COL_W;
	localparam int LINE_DEPTH  = 1 << LA_W;
	localparam int WD_W        = ($clog2(MAX_WIDTH + 1) > WREG_W) ?
		$clog2(MAX_WIDTH + 1) : WREG_W;
	localparam int MAX_RADIUS  = (MAX_KERNEL - 1) / 2;
	localparam int LANES       = (CHANNELS < 3) ? CHANNELS : 3;
	localparam int ACC_W       = PROD_W + CA_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_MAC   = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [WREG_W-1:0] width_q;
	logic [ROW_W-1:0]  height_q;
	logic [1:0]        chan_q;
	logic [1:0]        radx_q;
	logic [1:0]        rady_q;

	logic [WD_W-1:0]   w_eff;
	logic [WD_W-1:0]   w_tmp;
	logic [COL_W-1:0]  w_m1;
	logic [ROW_W-1:0]  h_m1;
	logic [1:0]        nch;
	logic [1:0]        rx_e;
	logic [1:0]        ry_e;
	logic [2:0]        kw_m1;
	logic [2:0]        kh_m1;

	logic [2:0]        state_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic              done_q;
	logic [2:0]        ta_q;
	logic [2:0]        tb_q;
	logic [CA_W-1:0]   cidx_q;
	logic              drain_q;
	logic              tap_s1_q;

	logic              accept;
	logic              cfg_wr;
	logic [2:0]        cfg_idx;
	logic              cfg_hit;
	logic [ROW_W:0]    need_r_w;
	logic [ROW_W-1:0]  need_r;
	logic [COL_W:0]    need_c_w;
	logic [COL_W-1:0]  need_c;
	logic              arrived;
	logic              last;
	logic              out_free;
	logic              tap_issue;
	logic [ROW_W+1:0]  rr;
	logic [ROW_W-1:0]  rr_c;
	logic [COL_W+1:0]  cc;
	logic [COL_W-1:0]  cc_c;
	logic [LA_W-1:0]   line_raddr;
	logic [LA_W-1:0]   line_waddr;

	logic [COEF_W-1:0]   coeff_mem [COEFF_DEPTH];
	logic [3*PIX_W-1:0]  line_mem [LINE_DEPTH];
	logic [COEF_W-1:0]   coef_s1;
	logic [3*PIX_W-1:0]  pix_s1;

	lane_ctrl_t              lane_ctrl;
	logic signed [ACC_W-1:0] sum [3];

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[APB_AW-1:2];

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:  cfg_hit = 1'b1;
			REG_HEIGHT: cfg_hit = 1'b1;
			REG_CHAN:   cfg_hit = 1'b1;
			REG_RADX:   cfg_hit = 1'b1;
			REG_RADY:   cfg_hit = 1'b1;
			default:    cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			chan_q   <= RST_CHAN;
			radx_q   <= RST_RAD;
			rady_q   <= RST_RAD;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[WREG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[ROW_W-1:0];
				REG_CHAN:   chan_q   <= pwdata[1:0];
				REG_RADX:   radx_q   <= pwdata[1:0];
				REG_RADY:   rady_q   <= pwdata[1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_CHAN:   prdata = APB_DW'(chan_q);
			REG_RADX:   prdata = APB_DW'(radx_q);
			REG_RADY:   prdata = APB_DW'(rady_q);
			default:    prdata = '0;
		endcase
	end

	// effective frame geometry
	always_comb begin
		if (width_q == '0) begin
			w_eff = WD_W'(1);
		end else if (WD_W'(width_q) > WD_W'(MAX_WIDTH)) begin
			w_eff = WD_W'(MAX_WIDTH);
		end else begin
			w_eff = WD_W'(width_q);
		end
		w_tmp = w_eff - WD_W'(1);
		w_m1  = w_tmp[COL_W-1:0];
		h_m1  = (height_q == '0) ? '0 : height_q - ROW_W'(1);
		if (chan_q == 2'd0) begin
			nch = 2'd1;
		end else if (int'(chan_q) > LANES) begin
			nch = 2'(LANES);
		end else begin
			nch = chan_q;
		end
		rx_e  = (int'(radx_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radx_q;
		ry_e  = (int'(rady_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : rady_q;
		kw_m1 = {rx_e, 1'b0};
		kh_m1 = {ry_e, 1'b0};
	end

	// has the bottom right corner of the next window arrived
	always_comb begin
		need_r_w = (ROW_W + 1)'(out_row_q) + (ROW_W + 1)'(ry_e);
		need_r   = (need_r_w > (ROW_W + 1)'(h_m1)) ? h_m1 : need_r_w[ROW_W-1:0];
		need_c_w = (COL_W + 1)'(out_col_q) + (COL_W + 1)'(rx_e);
		need_c   = (need_c_w > (COL_W + 1)'(w_m1)) ? w_m1 : need_c_w[COL_W-1:0];
		arrived  = done_q || (in_row_q > need_r) ||
			((in_row_q == need_r) && (in_col_q > need_c));
		last     = (out_row_q == h_m1) && (out_col_q == w_m1);
	end

	// tap address with the border replicated
	always_comb begin
		rr = (ROW_W + 2)'(out_row_q) + (ROW_W + 2)'(ry_e) - (ROW_W + 2)'(ta_q);
		if (rr[ROW_W+1]) begin
			rr_c = '0;
		end else if (rr > (ROW_W + 2)'(h_m1)) begin
			rr_c = h_m1;
		end else begin
			rr_c = rr[ROW_W-1:0];
		end
		cc = (COL_W + 2)'(out_col_q) + (COL_W + 2)'(rx_e) - (COL_W + 2)'(tb_q);
		if (cc[COL_W+1]) begin
			cc_c = '0;
		end else if (cc > (COL_W + 2)'(w_m1)) begin
			cc_c = w_m1;
		end else begin
			cc_c = cc[COL_W-1:0];
		end
		line_raddr = {rr_c[SLOT_W-1:0], cc_c};
		line_waddr = {in_row_q[SLOT_W-1:0], in_col_q};
	end

	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && items.ready;
	assign tap_issue   = (state_q == S_MAC);
	assign out_free    = !results.valid || results.ready;

	// kernel store
	always_ff @(posedge clk) begin
		if (accept && items.command == CMD_LOAD &&
				int'(items.coeff_index) < COEFF_DEPTH) begin
			coeff_mem[CA_W'(items.coeff_index)] <= items.coeff_value;
		end
		if (tap_issue) begin
			coef_s1 <= coeff_mem[cidx_q];
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (accept && items.command == CMD_PIXEL && !done_q) begin
			line_mem[line_waddr] <= {items.pixel_ch2, items.pixel_ch1, items.pixel_ch0};
		end
		if (tap_issue) begin
			pix_s1 <= line_mem[line_raddr];
		end
	end

	// sequencer and frame positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			done_q    <= 1'b0;
			ta_q      <= '0;
			tb_q      <= '0;
			cidx_q    <= '0;
			drain_q   <= 1'b0;
			tap_s1_q  <= 1'b0;
		end else begin
			tap_s1_q <= tap_issue;
			if (cfg_wr && cfg_hit) begin
				state_q   <= S_IDLE;
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
				done_q    <= 1'b0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							if (items.command == CMD_PIXEL) begin
								if (!done_q) begin
									if (in_col_q == w_m1) begin
										in_col_q <= '0;
										if (in_row_q == h_m1) begin
											in_row_q <= '0;
											done_q   <= 1'b1;
										end else begin
											in_row_q <= in_row_q + ROW_W'(1);
										end
									end else begin
										in_col_q <= in_col_q + COL_W'(1);
									end
								end
								state_q <= S_CHECK;
							end else if (items.command == CMD_FLUSH) begin
								state_q <= S_CHECK;
							end
						end
					end
					S_CHECK: begin
						ta_q   <= '0;
						tb_q   <= '0;
						cidx_q <= '0;
						state_q <= arrived ? S_MAC : S_IDLE;
					end
					S_MAC: begin
						cidx_q <= cidx_q + CA_W'(1);
						if (tb_q == kw_m1) begin
							tb_q <= '0;
							ta_q <= ta_q + 3'd1;
							if (ta_q == kh_m1) begin
								drain_q <= 1'b0;
								state_q <= S_DRAIN;
							end
						end else begin
							tb_q <= tb_q + 3'd1;
						end
					end
					S_DRAIN: begin
						drain_q <= 1'b1;
						if (drain_q) begin
							state_q <= S_EMIT;
						end
					end
					S_EMIT: begin
						if (out_free) begin
							state_q <= S_IDLE;
							if (last) begin
								out_row_q <= '0;
								out_col_q <= '0;
								done_q    <= 1'b0;
							end else if (out_col_q == w_m1) begin
								out_col_q <= '0;
								out_row_q <= out_row_q + ROW_W'(1);
							end else begin
								out_col_q <= out_col_q + COL_W'(1);
							end
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign lane_ctrl.clear  = (state_q == S_CHECK);
	assign lane_ctrl.tap_s1 = tap_s1_q;

	// one lane per channel
	for (genvar c = 0; c < 3; c++) begin : g_lane
		if (c < LANES) begin : g_on
			cv2d_lane #(
				.ACC_W (ACC_W)
			) u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (lane_ctrl),
				.coeff  ($signed(coef_s1)),
				.pixel  (pix_s1[c*PIX_W +: PIX_W]),
				.acc    (sum[c])
			);
		end else begin : g_off
			assign sum[c] = '0;
		end
	end

	cv2d_merge #(
		.ACC_W           (ACC_W),
		.COEFF_FRAC_BITS (COEFF_FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    ((state_q == S_EMIT) && out_free),
		.sum     (sum),
		.nch     (nch),
		.row     (out_row_q),
		.col     (OCOL_W'(out_col_q)),
		.last    (last),
		.results (results)
	);
endmodule

[tb/convolution_2d_replicate_border_test.sv]
module convolution_2d_replicate_border_test;
	import cv2d_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_ROWS   = DEF_MAX_KERNEL + 1;
	localparam int TAPS        = DEF_MAX_KERNEL * DEF_MAX_KERNEL;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]         command;
		logic [5:0]         coeff_index;
		logic signed [15:0] coeff_value;
		logic [7:0]         pix [3];
	} conv_item_t;

	typedef struct {
		logic [7:0]  ch [3];
		logic [15:0] row;
		logic [9:0]  col;
		logic        last;
	} conv_pixel_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	cv2d_in_if  items ();
	cv2d_out_if results ();

	convolution_2d_replicate_border dut (
		.clk(clk), .arst_n(arst_n), .items(items.sink), .results(results.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// mirror of the block's registers and storage
	logic [10:0]        img_w;
	logic [15:0]        img_h;
	logic [1:0]         chan_cnt;
	logic [1:0]         rad_x, rad_y;
	logic signed [15:0] kernel [TAPS];
	logic [7:0]         lines [LINE_ROWS*DEF_MAX_WIDTH][3];
	int unsigned        in_row, in_col, out_row, out_col;
	bit                 frame_in_done;

	conv_item_t  pending_items [$];
	conv_pixel_t expected_pixels [$];
	int          errors;
	int          cycles;
	int          pushed;
	bit          quiet;
	int          send_gap, take_gap;

	always #5 clk = ~clk;

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic restart_frame();
		in_row = 0; in_col = 0; out_row = 0; out_col = 0; frame_in_done = 0;
	endtask

	function automatic int unsigned eff_w();
		if (img_w == 0) return 1;
		if (img_w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return img_w;
	endfunction

	function automatic int unsigned eff_h();
		return img_h == 0 ? 1 : img_h;
	endfunction

	function automatic int unsigned eff_ch();
		return chan_cnt == 0 ? 1 : chan_cnt;
	endfunction

	function automatic logic [7:0] filter_channel(input int c, input int row, input int col);
		int w, h, rx, ry, rr, cc;
		longint acc;
		w = eff_w(); h = eff_h(); rx = rad_x; ry = rad_y;
		acc = 0;
		for (int a = -ry; a <= ry; a++) begin
			rr = row - a;
			if (rr < 0) rr = 0;
			if (rr > h - 1) rr = h - 1;
			for (int b = -rx; b <= rx; b++) begin
				cc = col - b;
				if (cc < 0) cc = 0;
				if (cc > w - 1) cc = w - 1;
				acc += longint'(kernel[(a + ry) * (2 * rx + 1) + (b + rx)]) *
					longint'(lines[(rr % LINE_ROWS) * DEF_MAX_WIDTH + cc][c]);
			end
		end
		if (acc <= 0) return 8'd0;
		acc = acc >>> DEF_COEFF_FRAC_BITS;
		return acc > 255 ? 8'd255 : acc[7:0];
	endfunction

	// advance the mirror by one accepted beat, queue the output it releases
	task automatic convolve_beat(input conv_item_t it);
		int unsigned w, h, need_r, need_c;
		bit arrived;
		conv_pixel_t px;
		w = eff_w(); h = eff_h();
		if (it.command == CMD_LOAD) begin
			if (it.coeff_index < TAPS) kernel[it.coeff_index] = it.coeff_value;
			return;
		end
		if (it.command != CMD_PIXEL && it.command != CMD_FLUSH) return;
		if (it.command == CMD_PIXEL && !frame_in_done) begin
			for (int c = 0; c < 3; c++)
				lines[(in_row % LINE_ROWS) * DEF_MAX_WIDTH + in_col][c] = it.pix[c];
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) begin
					in_row = 0;
					frame_in_done = 1;
				end
			end
		end
		need_r = out_row + rad_y;
		need_c = out_col + rad_x;
		if (need_r > h - 1) need_r = h - 1;
		if (need_c > w - 1) need_c = w - 1;
		arrived = frame_in_done || in_row > need_r || (in_row == need_r && in_col > need_c);
		if (!arrived) return;
		for (int c = 0; c < 3; c++)
			px.ch[c] = c < eff_ch() ? filter_channel(c, out_row, out_col) : 8'd0;
		px.row  = out_row[15:0];
		px.col  = out_col[9:0];
		px.last = out_row == h - 1 && out_col == w - 1;
		expected_pixels.push_back(px);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		if (px.last) begin
			out_row = 0; out_col = 0; frame_in_done = 0;
		end
	endtask

	// item driver
	always @(posedge clk) begin
		if (items.valid && items.ready) begin
			convolve_beat(pending_items.pop_front());
		end
		// a beat still waiting stays on the bus unchanged
		if (items.valid && !items.ready) begin
			items.valid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap--;
			items.valid <= 1'b0;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			send_gap = $urandom_range(0, 5);
			items.valid <= 1'b0;
		end else if (pending_items.size() > 0) begin
			items.valid       <= 1'b1;
			items.command     <= pending_items[0].command;
			items.coeff_index <= pending_items[0].coeff_index;
			items.coeff_value <= pending_items[0].coeff_value;
			items.pixel_ch0   <= pending_items[0].pix[0];
			items.pixel_ch1   <= pending_items[0].pix[1];
			items.pixel_ch2   <= pending_items[0].pix[2];
		end else begin
			items.valid <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		conv_pixel_t px;
		if (results.valid && results.ready) begin
			if (expected_pixels.size() == 0) begin
				report($sformatf("unexpected output row %0d col %0d",
					results.out_row, results.out_col));
			end else begin
				px = expected_pixels.pop_front();
				if (results.out_ch0 !== px.ch[0] || results.out_ch1 !== px.ch[1] ||
					results.out_ch2 !== px.ch[2] || results.out_row !== px.row ||
					results.out_col !== px.col || results.last_of_frame !== px.last)
					report($sformatf("got %0d %0d %0d r%0d c%0d l%0d, want %0d %0d %0d r%0d c%0d l%0d",
						results.out_ch0, results.out_ch1, results.out_ch2, results.out_row,
						results.out_col, results.last_of_frame, px.ch[0], px.ch[1], px.ch[2],
						px.row, px.col, px.last));
			end
		end
		if (take_gap > 0) begin
			take_gap--;
			results.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			take_gap = $urandom_range(0, 5);
			results.ready <= 1'b0;
		end else begin
			results.ready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL convolution_2d_replicate_border");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] cmd, input logic [5:0] idx,
		input logic signed [15:0] cv, input logic [7:0] p0, input logic [7:0] p1,
		input logic [7:0] p2);
		conv_item_t it;
		it.command = cmd; it.coeff_index = idx; it.coeff_value = cv;
		it.pix[0] = p0; it.pix[1] = p1; it.pix[2] = p2;
		pending_items.push_back(it);
		pushed++;
	endtask

	task automatic push_pixel();
		push_item(CMD_PIXEL, 6'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	task automatic push_coeff(input int idx);
		logic signed [15:0] cv;
		cv = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12288) - 4096);
		push_item(CMD_LOAD, 6'(idx), cv, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// wait for the block to go quiet
	task automatic drain();
		wait (pending_items.size() == 0 && !items.valid);
		wait (expected_pixels.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_WIDTH:  img_w = val[10:0];
			REG_HEIGHT: img_h = val[15:0];
			REG_CHAN:   chan_cnt = val[1:0];
			REG_RADX:   rad_x = val[1:0];
			default:    rad_y = val[1:0];
		endcase
		restart_frame();
	endtask

	task automatic set_frame(input int w, input int h, input int ch, input int rx, input int ry);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_CHAN, ch);
		reg_write(REG_RADX, rx);
		reg_write(REG_RADY, ry);
	endtask

	// a frame of pixels amid stray loads and unknown commands, then flushes or pixels
	task automatic push_frame();
		int n;
		n = eff_w() * eff_h();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) push_coeff($urandom_range(0, 63));
			if ($urandom_range(0, 29) == 0)
				push_item(2'd3, 6'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
			push_pixel();
		end
		n = (rad_y + 1) * eff_w() + rad_x + 3;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) push_pixel();
			else push_item(CMD_FLUSH, 6'($urandom), 16'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int w, h;
		clk = 0; arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		items.valid = 0; items.command = CMD_FLUSH; items.coeff_index = '0;
		items.coeff_value = '0; items.pixel_ch0 = '0; items.pixel_ch1 = '0;
		items.pixel_ch2 = '0; results.ready = 0;
		errors = 0; cycles = 0; pushed = 0; quiet = 0; send_gap = 0; take_gap = 0;
		img_w = RST_WIDTH; img_h = RST_HEIGHT; chan_cnt = RST_CHAN;
		rad_x = RST_RAD; rad_y = RST_RAD;
		restart_frame();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// full kernel with extremes, ignored loads and the unknown command
		for (int i = 0; i < TAPS; i++)
			push_item(CMD_LOAD, 6'(i),
				i % 3 == 0 ? -16'sd32768 : (i % 3 == 1 ? 16'sd32767 : 16'sd2048),
				8'd0, 8'd0, 8'd0);
		push_item(CMD_LOAD, 6'd63, 16'sd1, 8'd0, 8'd0, 8'd0);
		push_item(CMD_LOAD, 6'd49, 16'sd1, 8'd0, 8'd0, 8'd0);
		push_item(2'd3, 6'd63, -16'sd1, 8'hff, 8'hff, 8'hff);
		drain();

		// tiny frame with extreme pixels, nothing ready at first
		set_frame(3, 2, 3, 1, 1);
		push_item(CMD_FLUSH, 6'd0, 16'sd0, 8'd0, 8'd0, 8'd0);
		for (int i = 0; i < 6; i++)
			push_item(CMD_PIXEL, 6'd0, 16'sd0, i[0] ? 8'hff : 8'h00, i[0] ? 8'h00 : 8'hff,
				8'hff);
		for (int i = 0; i < 8; i++) push_item(CMD_FLUSH, 6'd0, 16'sd0, 8'd0, 8'd0, 8'd0);
		drain();

		// widest row, clamped from the register's largest value; every pixel
		// releases its own output with a one pixel window
		set_frame(2047, 1, 0, 0, 0);
		for (int i = 0; i < eff_w(); i++) push_pixel();
		drain();

		// tallest frame, only partly streamed; degenerate sizes
		set_frame(2, 65535, 2, 3, 3);
		for (int i = 0; i < 30; i++) push_pixel();
		drain();
		set_frame(0, 0, 1, 3, 0);
		push_frame();
		drain();

		while (pushed < 1250) begin
			if (pushed > 1150) quiet = 1;
			w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(1, 8);
			h = $urandom_range(0, 6);
			set_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
			for (int i = 0; i < TAPS; i++)
				if ($urandom_range(0, 2) == 0) push_coeff(i);
			repeat ($urandom_range(1, 2)) push_frame();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, eff_w() * eff_h())) push_pixel();
			drain();
		end

		wait (expected_pixels.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("PASS convolution_2d_replicate_border");
		else $display("FAIL convolution_2d_replicate_border");
		$finish;
	end

endmodule
